// ===== sv/hpa_pkg.sv =====
// ----------------------------------------------------------------------------
// hpa_pkg
// Shared constants, codes and token types of the huge page pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package hpa_pkg;

  localparam int DEF_SMALL_POOL_DEPTH  = 64;
  localparam int DEF_LARGE_POOL_DEPTH  = 8;
  localparam int DEF_APP_COUNT         = 16;
  localparam int DEF_PAGE_NUMBER_WIDTH = 36;

  localparam int OP_W         = 2;
  localparam int STATUS_W     = 2;
  localparam int APP_NUM_W    = 4;
  localparam int RELEASED_W   = 7;
  localparam int SMALL_CNT_W  = 7;
  localparam int LARGE_CNT_W  = 4;
  localparam int CFG_INDEX_W  = 2;

  localparam int SMALL_SHIFT  = 9;
  localparam int LARGE_SHIFT  = 18;
  localparam longint SMALL_SPAN = 64'd1 << SMALL_SHIFT;
  localparam longint LARGE_SPAN = 64'd1 << LARGE_SHIFT;
  localparam longint BASE_RESET = 64'h10_0000;

  localparam logic [OP_W-1:0] OP_ALLOC    = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE     = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE_ALL = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE     = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DISABLED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SMALL  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LARGE  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BASE   = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            is_1g;
  } req_ctl_t;

  typedef struct packed {
    logic valid;
    logic hit;
  } tok_ctl_t;

endpackage

`default_nettype wire

// ===== sv/hpa_cell.sv =====
// ----------------------------------------------------------------------------
// hpa_cell
// One page slot: busy flag and owner, acting on the request token that
// passes through and handing the token on to the next slot.
// ----------------------------------------------------------------------------
`default_nettype none

module hpa_cell #(
  parameter bit IS_LARGE = 1'b0,
  parameter int INDEX    = 0,
  parameter int LIM_W    = 1,
  parameter int PNW      = 36,
  parameter int AW       = 4,
  parameter int SCW      = 7,
  parameter int LCW      = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               clear_i,
  input  logic [LIM_W-1:0]   lim_i,
  input  hpa_pkg::req_ctl_t  req_i,
  input  logic [AW-1:0]      app_i,
  input  logic [PNW-1:0]     page_i,
  input  hpa_pkg::tok_ctl_t  ctl_i,
  input  logic [PNW-1:0]     addr_i,
  input  logic [PNW-1:0]     gr_i,
  input  logic [AW-1:0]      own_i,
  input  logic [SCW-1:0]     rs_i,
  input  logic [LCW-1:0]     rl_i,
  output hpa_pkg::tok_ctl_t  ctl_o,
  output logic [PNW-1:0]     addr_o,
  output logic [PNW-1:0]     gr_o,
  output logic [AW-1:0]      own_o,
  output logic [SCW-1:0]     rs_o,
  output logic [LCW-1:0]     rl_o
);
  import hpa_pkg::*;

  localparam logic [PNW-1:0] SPAN = IS_LARGE ? PNW'(LARGE_SPAN) : PNW'(SMALL_SPAN);

  logic          busy_r;
  logic [AW-1:0] owner_r;
  tok_ctl_t      ctl_r;
  logic [PNW-1:0] addr_r;
  logic [PNW-1:0] gr_r;
  logic [AW-1:0]  own_r;
  logic [SCW-1:0] rs_r;
  logic [LCW-1:0] rl_r;

  logic active;
  logic pool_ok;
  logic alloc_hit;
  logic free_hit;
  logic fa_hit;
  logic [PNW-1:0] addr_nxt;

  assign active  = int'(lim_i) > INDEX;
  assign pool_ok = req_i.is_1g == IS_LARGE;

  assign alloc_hit = ctl_i.valid && !ctl_i.hit && req_i.op == OP_ALLOC && pool_ok
                     && active && !busy_r;
  assign free_hit  = ctl_i.valid && !ctl_i.hit && req_i.op == OP_FREE && pool_ok
                     && active && busy_r && addr_i == page_i;
  assign fa_hit    = ctl_i.valid && req_i.op == OP_FREE_ALL && active && busy_r
                     && owner_r == app_i;

  // small slots past the pool size do not advance the address
  assign addr_nxt = (active || IS_LARGE) ? addr_i + SPAN : addr_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ctl_r  <= '0;
    end else begin
      if (clear_i) begin
        busy_r <= 1'b0;
      end else if (alloc_hit) begin
        busy_r <= 1'b1;
      end else if (free_hit || fa_hit) begin
        busy_r <= 1'b0;
      end
      ctl_r.valid <= ctl_i.valid;
      ctl_r.hit   <= ctl_i.hit || alloc_hit || free_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (alloc_hit) begin
      owner_r <= app_i;
    end
    addr_r <= addr_nxt;
    gr_r   <= alloc_hit ? addr_i : gr_i;
    own_r  <= free_hit ? owner_r : own_i;
    rs_r   <= (fa_hit && !IS_LARGE) ? rs_i + SCW'(1) : rs_i;
    rl_r   <= (fa_hit && IS_LARGE) ? rl_i + LCW'(1) : rl_i;
  end

  assign ctl_o  = ctl_r;
  assign addr_o = addr_r;
  assign gr_o   = gr_r;
  assign own_o  = own_r;
  assign rs_o   = rs_r;
  assign rl_o   = rl_r;

endmodule

`default_nettype wire

// ===== sv/huge_page_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// huge_page_pool_allocator
// First-fit allocator for a pool of 2MB page slots and a pool of 1GB slots.
// ----------------------------------------------------------------------------
// Allocate, free and free-all requests travel as a token through a chain of
// SMALL_POOL_DEPTH + LARGE_POOL_DEPTH slot cells, 2MB slots first, one cell
// per cycle; the first free (or matching) slot along the chain takes an
// allocate or free request, so the lowest slot wins, and a free-all releases
// every slot that the application holds. One request is handled at a time: a
// serviced request is swept through the chain and reported before the next is
// accepted; a request made while disabled, or with the unused opcode, goes
// straight to the report. A finished result sits in the output register while
// the next request is accepted; a result that finds the output register still
// full waits in the report state until the previous result is taken. A
// configuration write clears both pools and all per-application usage in the
// cycle after it; requests wait for that cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module huge_page_pool_allocator #(
  parameter int SMALL_POOL_DEPTH  = hpa_pkg::DEF_SMALL_POOL_DEPTH,
  parameter int LARGE_POOL_DEPTH  = hpa_pkg::DEF_LARGE_POOL_DEPTH,
  parameter int APP_COUNT         = hpa_pkg::DEF_APP_COUNT,
  parameter int PAGE_NUMBER_WIDTH = hpa_pkg::DEF_PAGE_NUMBER_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [hpa_pkg::OP_W-1:0]        in_opcode,
  input  logic                            in_page_size,
  input  logic [hpa_pkg::APP_NUM_W-1:0]   in_app_number,
  input  logic [PAGE_NUMBER_WIDTH-1:0]    in_page_to_free,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [hpa_pkg::STATUS_W-1:0]    out_status,
  output logic [PAGE_NUMBER_WIDTH-1:0]    out_granted_page,
  output logic [hpa_pkg::RELEASED_W-1:0]  out_released_count,
  output logic [hpa_pkg::SMALL_CNT_W-1:0] out_small_free,
  output logic [hpa_pkg::LARGE_CNT_W-1:0] out_large_free,
  output logic [hpa_pkg::SMALL_CNT_W-1:0] out_app_small_usage,
  output logic [hpa_pkg::LARGE_CNT_W-1:0] out_app_large_usage,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hpa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [PAGE_NUMBER_WIDTH-1:0]    cfg_data
);
  import hpa_pkg::*;

  localparam int N   = SMALL_POOL_DEPTH + LARGE_POOL_DEPTH;
  localparam int PNW = PAGE_NUMBER_WIDTH;
  localparam int SCW = $clog2(SMALL_POOL_DEPTH + 1);
  localparam int LCW = $clog2(LARGE_POOL_DEPTH + 1);
  localparam int AW  = (APP_COUNT > 1) ? $clog2(APP_COUNT) : 1;
  localparam int RW  = ((SCW > LCW) ? SCW : LCW) + 1;
  localparam int APP_VALUES = 1 << APP_NUM_W;

  typedef enum logic [1:0] {
    IDLE,
    SWEEP,
    REPORT
  } state_t;

  state_t state_r;

  logic                   enable_r;
  logic [SMALL_CNT_W-1:0] small_pages_r;
  logic [LARGE_CNT_W-1:0] large_pages_r;
  logic [PNW-1:0]         base_r;
  logic                   clear_r;

  logic [SCW-1:0] eff_small;
  logic [LCW-1:0] eff_large;

  logic [OP_W-1:0] req_op_r;
  logic            req_large_r;
  logic [AW-1:0]   req_app_r;
  logic [PNW-1:0]  req_page_r;
  req_ctl_t        req_ctl;
  logic            inj_r;

  logic [SCW-1:0] small_free_r;
  logic [LCW-1:0] large_free_r;
  logic [SCW-1:0] su_r [APP_COUNT];
  logic [LCW-1:0] lu_r [APP_COUNT];

  logic [STATUS_W-1:0]   res_status_r;
  logic [PNW-1:0]        res_granted_r;
  logic [RELEASED_W-1:0] res_rel_r;

  logic                   out_valid_r;
  logic [STATUS_W-1:0]    out_status_r;
  logic [PNW-1:0]         out_granted_r;
  logic [RELEASED_W-1:0]  out_rel_r;
  logic [SMALL_CNT_W-1:0] out_small_free_r;
  logic [LARGE_CNT_W-1:0] out_large_free_r;
  logic [SMALL_CNT_W-1:0] out_app_small_r;
  logic [LARGE_CNT_W-1:0] out_app_large_r;

  logic [AW-1:0] app_mod_tbl [APP_VALUES];
  logic [AW-1:0] in_app;
  logic          in_acc;
  logic          cfg_acc;
  logic          go;

  tok_ctl_t       ctl_w  [N+1];
  logic [PNW-1:0] addr_w [N+1];
  logic [PNW-1:0] gr_w   [N+1];
  logic [AW-1:0]  own_w  [N+1];
  logic [SCW-1:0] rs_w   [N+1];
  logic [LCW-1:0] rl_w   [N+1];
  logic [N:0]     tok_valid_vec;

  // application number folded into range
  for (genvar v = 0; v < APP_VALUES; v++) begin : g_app_mod
    assign app_mod_tbl[v] = AW'(v % APP_COUNT);
  end

  assign in_app  = app_mod_tbl[in_app_number];
  assign in_ready = (state_r == IDLE) && !clear_r;
  assign in_acc  = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_acc = cfg_valid && cfg_ready;
  assign go = enable_r && (in_opcode == OP_ALLOC || in_opcode == OP_FREE
                           || in_opcode == OP_FREE_ALL);

  assign eff_small = (int'(small_pages_r) > SMALL_POOL_DEPTH) ?
                     SCW'(SMALL_POOL_DEPTH) : SCW'(small_pages_r);
  assign eff_large = (int'(large_pages_r) > LARGE_POOL_DEPTH) ?
                     LCW'(LARGE_POOL_DEPTH) : LCW'(large_pages_r);

  assign req_ctl.op    = req_op_r;
  assign req_ctl.is_1g = req_large_r;

  // token entering the chain
  assign ctl_w[0].valid = inj_r;
  assign ctl_w[0].hit   = 1'b0;
  assign addr_w[0] = base_r;
  assign gr_w[0]   = '0;
  assign own_w[0]  = '0;
  assign rs_w[0]   = '0;
  assign rl_w[0]   = '0;

  for (genvar k = 0; k <= N; k++) begin : g_tok_valid
    assign tok_valid_vec[k] = ctl_w[k].valid;
  end

  for (genvar k = 0; k < N; k++) begin : g_chain
    if (k < SMALL_POOL_DEPTH) begin : g_small
      hpa_cell #(
        .IS_LARGE (1'b0),
        .INDEX    (k),
        .LIM_W    (SCW),
        .PNW      (PNW),
        .AW       (AW),
        .SCW      (SCW),
        .LCW      (LCW)
      ) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear_i (clear_r),
        .lim_i   (eff_small),
        .req_i   (req_ctl),
        .app_i   (req_app_r),
        .page_i  (req_page_r),
        .ctl_i   (ctl_w[k]),
        .addr_i  (addr_w[k]),
        .gr_i    (gr_w[k]),
        .own_i   (own_w[k]),
        .rs_i    (rs_w[k]),
        .rl_i    (rl_w[k]),
        .ctl_o   (ctl_w[k+1]),
        .addr_o  (addr_w[k+1]),
        .gr_o    (gr_w[k+1]),
        .own_o   (own_w[k+1]),
        .rs_o    (rs_w[k+1]),
        .rl_o    (rl_w[k+1])
      );
    end else begin : g_large
      hpa_cell #(
        .IS_LARGE (1'b1),
        .INDEX    (k - SMALL_POOL_DEPTH),
        .LIM_W    (LCW),
        .PNW      (PNW),
        .AW       (AW),
        .SCW      (SCW),
        .LCW      (LCW)
      ) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear_i (clear_r),
        .lim_i   (eff_large),
        .req_i   (req_ctl),
        .app_i   (req_app_r),
        .page_i  (req_page_r),
        .ctl_i   (ctl_w[k]),
        .addr_i  (addr_w[k]),
        .gr_i    (gr_w[k]),
        .own_i   (own_w[k]),
        .rs_i    (rs_w[k]),
        .rl_i    (rl_w[k]),
        .ctl_o   (ctl_w[k+1]),
        .addr_o  (addr_w[k+1]),
        .gr_o    (gr_w[k+1]),
        .own_o   (own_w[k+1]),
        .rs_o    (rs_w[k+1]),
        .rl_o    (rl_w[k+1])
      );
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r      <= 1'b0;
      small_pages_r <= '0;
      large_pages_r <= '0;
      base_r        <= PNW'(BASE_RESET);
      clear_r       <= 1'b0;
    end else begin
      clear_r <= cfg_acc;
      if (cfg_acc) begin
        unique case (cfg_index)
          CFG_ENABLE: enable_r      <= cfg_data[0];
          CFG_SMALL:  small_pages_r <= cfg_data[SMALL_CNT_W-1:0];
          CFG_LARGE:  large_pages_r <= cfg_data[LARGE_CNT_W-1:0];
          CFG_BASE:   base_r        <= cfg_data;
        endcase
      end
    end
  end

  // request fields, held for the sweep
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_op_r    <= in_opcode;
      req_large_r <= in_page_size;
      req_app_r   <= in_app;
      req_page_r  <= in_page_to_free;
    end
  end

  // sequencer, pool counters and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= IDLE;
      inj_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      small_free_r <= '0;
      large_free_r <= '0;
      for (int a = 0; a < APP_COUNT; a++) begin
        su_r[a] <= '0;
        lu_r[a] <= '0;
      end
    end else begin
      inj_r <= in_acc && go;
      if (out_valid_r && out_ready && state_r != REPORT) begin
        out_valid_r <= 1'b0;
      end
      if (clear_r) begin
        small_free_r <= eff_small;
        large_free_r <= eff_large;
        for (int a = 0; a < APP_COUNT; a++) begin
          su_r[a] <= '0;
          lu_r[a] <= '0;
        end
      end
      unique case (state_r)
        IDLE: begin
          if (in_acc) begin
            res_granted_r <= '0;
            res_rel_r     <= '0;
            if (go) begin
              state_r <= SWEEP;
            end else begin
              res_status_r <= enable_r ? ST_OK : ST_DISABLED;
              state_r      <= REPORT;
            end
          end
        end
        SWEEP: begin
          if (ctl_w[N].valid) begin
            state_r <= REPORT;
            case (req_op_r)
              OP_ALLOC: begin
                if (ctl_w[N].hit) begin
                  res_status_r  <= ST_OK;
                  res_granted_r <= gr_w[N];
                  if (!req_large_r) begin
                    su_r[req_app_r] <= su_r[req_app_r] + SCW'(1);
                    if (small_free_r != '0) begin
                      small_free_r <= small_free_r - SCW'(1);
                    end
                  end else begin
                    lu_r[req_app_r] <= lu_r[req_app_r] + LCW'(1);
                    if (large_free_r != '0) begin
                      large_free_r <= large_free_r - LCW'(1);
                    end
                  end
                end else begin
                  res_status_r <= ST_EXHAUSTED;
                end
              end
              OP_FREE: begin
                if (ctl_w[N].hit) begin
                  res_status_r <= ST_OK;
                  res_rel_r    <= RELEASED_W'(1);
                  if (!req_large_r) begin
                    small_free_r <= small_free_r + SCW'(1);
                    if (su_r[own_w[N]] != '0) begin
                      su_r[own_w[N]] <= su_r[own_w[N]] - SCW'(1);
                    end
                  end else begin
                    large_free_r <= large_free_r + LCW'(1);
                    if (lu_r[own_w[N]] != '0) begin
                      lu_r[own_w[N]] <= lu_r[own_w[N]] - LCW'(1);
                    end
                  end
                end else begin
                  res_status_r <= ST_NOT_FOUND;
                end
              end
              default: begin
                res_status_r    <= ST_OK;
                res_rel_r       <= RELEASED_W'(RW'(rs_w[N]) + RW'(rl_w[N]));
                small_free_r    <= small_free_r + rs_w[N];
                large_free_r    <= large_free_r + rl_w[N];
                su_r[req_app_r] <= '0;
                lu_r[req_app_r] <= '0;
              end
            endcase
          end
        end
        REPORT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r      <= 1'b1;
            out_status_r     <= res_status_r;
            out_granted_r    <= res_granted_r;
            out_rel_r        <= res_rel_r;
            out_small_free_r <= SMALL_CNT_W'(small_free_r);
            out_large_free_r <= LARGE_CNT_W'(large_free_r);
            out_app_small_r  <= SMALL_CNT_W'(su_r[req_app_r]);
            out_app_large_r  <= LARGE_CNT_W'(lu_r[req_app_r]);
            state_r          <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_granted_page    = out_granted_r;
  assign out_released_count  = out_rel_r;
  assign out_small_free      = out_small_free_r;
  assign out_large_free      = out_large_free_r;
  assign out_app_small_usage = out_app_small_r;
  assign out_app_large_usage = out_app_large_r;

`ifndef NO_ASSERTIONS
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_valid_vec))
    else $error("more than one request token in the slot chain");

  a_token_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_w[N].valid |-> state_r == SWEEP)
    else $error("token left the chain outside a sweep");

  a_chain_end_addr: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_w[N].valid |-> addr_w[N] == base_r + (PNW'(eff_small) << SMALL_SHIFT)
                                   + (PNW'(LARGE_POOL_DEPTH) << LARGE_SHIFT))
    else $error("slot address chain out of step with pool sizes");

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !clear_r |-> (small_free_r <= eff_small && large_free_r <= eff_large))
    else $error("free count above pool size");

  a_result_from_report: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == REPORT))
    else $error("result raised outside report state");
`endif

endmodule

`default_nettype wire
